/* src/swrc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and the bytewise CRC function for the stop-and-wait receiver.
// Used by swrc_engine and stop_and_wait_receiver_crc_core; depends on nothing else.
package swrc_pkg;

    localparam int unsigned MAX_LEN = 256;
    localparam int CNT_W = 9;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef enum logic [1:0] {
        PKT_SYN = 2'd0,
        PKT_FIN = 2'd1,
        PKT_ACK = 2'd2,
        PKT_NAK = 2'd3
    } pkt_type_t;

    typedef enum logic [1:0] {
        RESP_NONE = 2'd0,
        RESP_ACK  = 2'd1,
        RESP_NAK  = 2'd2
    } resp_kind_t;

    typedef enum logic [2:0] {
        OUT_DELIVERED = 3'd0,
        OUT_FINISHED  = 3'd1,
        OUT_CRC_ERR   = 3'd2,
        OUT_ORDER_ERR = 3'd3,
        OUT_DUPLICATE = 3'd4,
        OUT_BAD_TYPE  = 3'd5,
        OUT_TOO_LONG  = 3'd6
    } outcome_t;

    typedef struct packed {
        pkt_type_t   pkt_kind;
        logic [31:0] seq_no;
        logic [15:0] check_value;
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        last_item;
    } item_t;

    typedef struct packed {
        resp_kind_t       response_kind;
        logic [31:0]      response_seq;
        outcome_t         outcome;
        logic [CNT_W-1:0] byte_count;
    } result_t;

    // CRC-16/CCITT-FALSE, one byte per call, polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ (x >> 4);
        return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
    endfunction

endpackage

/* src/swrc_engine.sv */
`timescale 1ns / 1ps
// Packet state and decision logic: running CRC, payload count, session and sequence.
// Depends on swrc_pkg.
module swrc_engine
    import swrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    logic [15:0]      crc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             too_long_reg;
    logic             session_reg;
    logic [31:0]      expected_reg;

    logic [15:0]      crc_next;
    logic [CNT_W-1:0] cnt_next;
    logic             too_long_next;
    logic             session_next;
    logic [31:0]      expected_next;

    logic             start;
    logic             session_s;
    logic [31:0]      expected_s;
    logic             session_f;
    logic [31:0]      expected_f;
    resp_kind_t       kind;
    outcome_t         outcome;

    always_comb
    begin
        crc_next      = crc_reg;
        cnt_next      = cnt_reg;
        too_long_next = too_long_reg;
        if (item.byte_valid)
        begin
            if (cnt_reg >= MAX_CNT)
            begin
                too_long_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                crc_next = crc16_byte(crc_reg, item.data_byte);
            end
        end

        start      = (item.pkt_kind == PKT_SYN) && (item.seq_no == 32'd0) && !session_reg;
        session_s  = session_reg | start;
        expected_s = start ? 32'd0 : expected_reg;
        session_f  = session_s;
        expected_f = expected_s;
        kind       = RESP_NONE;
        outcome    = OUT_DELIVERED;

        unique case (item.pkt_kind)
            PKT_SYN:
            begin
                priority if (too_long_next)
                begin
                    outcome = OUT_TOO_LONG;
                end
                else if (crc_next != item.check_value)
                begin
                    kind    = RESP_NAK;
                    outcome = OUT_CRC_ERR;
                end
                else if (session_s && item.seq_no == expected_s)
                begin
                    kind       = RESP_ACK;
                    outcome    = OUT_DELIVERED;
                    expected_f = expected_s + 32'd1;
                end
                else if (session_s && expected_s != 32'd0
                         && item.seq_no == expected_s - 32'd1)
                begin
                    kind    = RESP_ACK;
                    outcome = OUT_DUPLICATE;
                end
                else
                begin
                    outcome = OUT_ORDER_ERR;
                end
            end
            PKT_FIN:
            begin
                kind       = RESP_ACK;
                outcome    = OUT_FINISHED;
                session_f  = 1'b0;
                expected_f = 32'd0;
            end
            PKT_ACK, PKT_NAK:
            begin
                outcome = OUT_BAD_TYPE;
            end
        endcase

        result.response_kind = kind;
        result.response_seq  = item.seq_no;
        result.outcome       = outcome;
        result.byte_count    = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= CRC_INIT;
            cnt_reg      <= '0;
            too_long_reg <= 1'b0;
            session_reg  <= 1'b0;
            expected_reg <= 32'd0;
        end
        else if (step)
        begin
            if (item.last_item)
            begin
                crc_reg      <= CRC_INIT;
                cnt_reg      <= '0;
                too_long_reg <= 1'b0;
                session_reg  <= session_f;
                expected_reg <= expected_f;
            end
            else
            begin
                crc_reg      <= crc_next;
                cnt_reg      <= cnt_next;
                too_long_reg <= too_long_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_idle_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !session_reg |-> expected_reg == 32'd0)
        else $error("expected sequence nonzero without a session");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("payload count above limit");
    a_too_long_full: assert property (@(posedge clk) disable iff (!rst_n)
        too_long_reg |-> cnt_reg == MAX_CNT)
        else $error("overflow flag set before the count reached the limit");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.last_item) |=> (cnt_reg == '0 && crc_reg == CRC_INIT && !too_long_reg))
        else $error("packet state not cleared after the last request");
`endif

endmodule

/* src/stop_and_wait_receiver_crc_core.sv */
`timescale 1ns / 1ps
// Top level of the stop-and-wait receiver with CRC-16/CCITT-FALSE payload check.
// Depends on swrc_pkg and swrc_engine.
//
// The block takes one request per clock cycle: each carries one payload byte and the packet
// header, and tlast closes the packet. Valid bytes run through a CRC-16/CCITT-FALSE (init
// 0xFFFF) and are counted up to 256; more bytes mark the packet too long. On the last request
// the block decides and delivers exactly one result with the reply kind, the packet's
// sequence number, the outcome and the byte count; other requests give no result. A request
// is held in the input register until it advances; as it advances, the CRC, count and session
// state take its update and the result of a last request enters the output register.
// The session and CRC state is updated once per cycle, which sets the rate of one request
// per cycle; the input stalls only while a last request waits in the input register and the
// output register still holds an earlier result that the receiver has not taken.
module stop_and_wait_receiver_crc_core
    import swrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // seq_no[31:0], check_value[47:32], data_byte[55:48]
    input  logic [2:0]  s_axis_tuser,  // pkt_kind[1:0], byte_valid[2]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // response_seq[31:0], outcome[34:32], byte_count[43:35]
    output logic [1:0]  m_axis_tuser   // response_kind[1:0]
);

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t result;
    logic    out_free;
    logic    advance;
    logic    in_take;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_item_reg.last_item || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && in_item_reg.last_item)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.pkt_kind    <= pkt_type_t'(s_axis_tuser[1:0]);
            in_item_reg.seq_no      <= s_axis_tdata[31:0];
            in_item_reg.check_value <= s_axis_tdata[47:32];
            in_item_reg.data_byte   <= s_axis_tdata[55:48];
            in_item_reg.byte_valid  <= s_axis_tuser[2];
            in_item_reg.last_item   <= s_axis_tlast;
        end
        if (advance && in_item_reg.last_item)
        begin
            out_reg <= result;
        end
    end

    swrc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.response_kind;
    assign m_axis_tdata  = {4'b0000, out_reg.byte_count, out_reg.outcome, out_reg.response_seq};

`ifndef ASSERT_OFF
    a_nak_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.response_kind == RESP_NAK) |-> out_reg.outcome == OUT_CRC_ERR)
        else $error("NAK sent for an outcome other than a CRC error");
    a_ack_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.response_kind == RESP_ACK) |->
        (out_reg.outcome == OUT_DELIVERED || out_reg.outcome == OUT_FINISHED
         || out_reg.outcome == OUT_DUPLICATE))
        else $error("ACK sent for a failed packet");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !(advance && in_item_reg.last_item))
        else $error("result overwritten while waiting");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stop_and_wait_receiver_crc_core: drives packets as byte requests
// and checks every reply against a scoreboard that predicts the block's own behavior.
// Depends on swrc_pkg and the RTL of the block.
module testbench;
    import swrc_pkg::*;

    class reply_scoreboard;
        logic [15:0] crc_acc;
        int unsigned byte_tally;
        bit          overflow;
        bit          in_session;
        logic [31:0] next_seq;
        result_t     replies_due[$];
        int          errors;
        int          results_seen;

        function new();
            crc_acc = CRC_INIT;
            byte_tally = 0;
            overflow = 0;
            in_session = 0;
            next_seq = '0;
            errors = 0;
            results_seen = 0;
        endfunction

        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++)
                c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
            return c;
        endfunction

        task flag_mismatch(string msg);
            $display("reply error at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Every accepted request goes through here; the last one of a packet queues its reply.
        function void take_request(item_t it);
            result_t r;
            if (it.byte_valid)
            begin
                if (byte_tally >= MAX_LEN)
                    overflow = 1;
                else
                begin
                    byte_tally++;
                    crc_acc = crc_step(crc_acc, it.data_byte);
                end
            end
            if (!it.last_item)
                return;
            r.response_kind = RESP_NONE;
            r.response_seq = it.seq_no;
            r.byte_count = byte_tally[CNT_W-1:0];
            case (it.pkt_kind)
                PKT_SYN:
                begin
                    if (it.seq_no == 0 && !in_session)
                    begin
                        in_session = 1;
                        next_seq = '0;
                    end
                    if (overflow)
                        r.outcome = OUT_TOO_LONG;
                    else if (crc_acc != it.check_value)
                    begin
                        r.response_kind = RESP_NAK;
                        r.outcome = OUT_CRC_ERR;
                    end
                    else if (in_session && it.seq_no == next_seq)
                    begin
                        r.response_kind = RESP_ACK;
                        r.outcome = OUT_DELIVERED;
                        next_seq = next_seq + 1;
                    end
                    else if (in_session && next_seq != 0 && it.seq_no == next_seq - 1)
                    begin
                        r.response_kind = RESP_ACK;
                        r.outcome = OUT_DUPLICATE;
                    end
                    else
                        r.outcome = OUT_ORDER_ERR;
                end
                PKT_FIN:
                begin
                    r.response_kind = RESP_ACK;
                    r.outcome = OUT_FINISHED;
                    in_session = 0;
                    next_seq = '0;
                end
                default:
                    r.outcome = OUT_BAD_TYPE;
            endcase
            replies_due.push_back(r);
            crc_acc = CRC_INIT;
            byte_tally = 0;
            overflow = 0;
        endfunction

        task check_reply(result_t got, logic [3:0] pad);
            result_t want;
            results_seen++;
            if (replies_due.size() == 0)
            begin
                flag_mismatch($sformatf("reply with none pending, seq %0h", got.response_seq));
                return;
            end
            want = replies_due.pop_front();
            if (got.response_kind !== want.response_kind)
                flag_mismatch($sformatf("seq %0h kind %0d want %0d", want.response_seq,
                    got.response_kind, want.response_kind));
            if (got.response_seq !== want.response_seq)
                flag_mismatch($sformatf("seq %0h want %0h", got.response_seq,
                    want.response_seq));
            if (got.outcome !== want.outcome)
                flag_mismatch($sformatf("seq %0h outcome %0d want %0d", want.response_seq,
                    got.outcome, want.outcome));
            if (got.byte_count !== want.byte_count)
                flag_mismatch($sformatf("seq %0h count %0d want %0d", want.response_seq,
                    got.byte_count, want.byte_count));
            if (pad !== 4'b0000)
                flag_mismatch($sformatf("seq %0h padding bits %b", want.response_seq, pad));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    reply_scoreboard sb = new();
    int items_sent = 0;
    bit tx_steady = 0;

    stop_and_wait_receiver_crc_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic send_item(item_t it);
        @(negedge clk);
        while (!tx_steady && $urandom_range(99) < 25)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {it.data_byte, it.check_value, it.seq_no};
        s_axis_tuser = {it.byte_valid, it.pkt_kind};
        s_axis_tlast = it.last_item;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.take_request(it);
        items_sent++;
    endtask

    task automatic send_packet(pkt_type_t kind, logic [31:0] seq, int n_items, bit crc_ok,
                               int valid_pct, int fill);
        item_t it;
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int k = 0; k < n_items; k++)
        begin
            it.pkt_kind = kind;
            it.seq_no = seq;
            it.byte_valid = ($urandom_range(99) < valid_pct);
            it.data_byte = (fill < 0) ? 8'($urandom) : fill[7:0];
            it.last_item = (k == n_items - 1);
            if (it.byte_valid)
                crc = reply_scoreboard::crc_step(crc, it.data_byte);
            if (!it.last_item)
                it.check_value = 16'($urandom);
            else if (crc_ok)
                it.check_value = crc;
            else
                it.check_value = crc ^ 16'($urandom_range(65535, 1));
            send_item(it);
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.response_kind = resp_kind_t'(m_axis_tuser);
            got.response_seq = m_axis_tdata[31:0];
            got.outcome = outcome_t'(m_axis_tdata[34:32]);
            got.byte_count = m_axis_tdata[43:35];
            sb.check_reply(got, m_axis_tdata[47:44]);
        end
    end

    // The reply side stalls at random, runs without stalls for a while, and once holds off
    // for a long stretch so that the block backs up and stalls its requests.
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && sb.results_seen >= 8)
            begin
                held = 1;
                hold_left = 60;
            end
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else if (sb.results_seen >= 40 && sb.results_seen < 60)
                m_axis_tready = 1'b1;
            else
                m_axis_tready = ($urandom_range(99) >= 25);
        end
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int p;
        int r;
        int n;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_packet(PKT_SYN, 32'd5, 1, 1, 100, -1);
        send_packet(PKT_SYN, 32'd0, 2, 1, 100, 8'h00);
        send_packet(PKT_SYN, 32'd1, 2, 1, 100, 8'hFF);
        send_packet(PKT_SYN, 32'd1, 1, 1, 100, -1);
        send_packet(PKT_SYN, 32'd2, 3, 0, 100, -1);
        send_packet(PKT_SYN, 32'd7, 1, 1, 100, -1);
        send_packet(PKT_ACK, 32'd2, 1, 1, 100, -1);
        send_packet(PKT_NAK, 32'hFFFF_FFFF, 1, 0, 100, -1);
        send_packet(PKT_SYN, 32'd2, 4, 1, 50, -1);
        send_packet(PKT_FIN, 32'd3, 2, 0, 100, -1);
        send_packet(PKT_SYN, 32'd0, 1, 0, 100, -1);
        send_packet(PKT_SYN, 32'hFFFF_FFFF, 1, 1, 100, -1);
        send_packet(PKT_SYN, 32'd0, 2, 1, 0, -1);
        send_packet(PKT_FIN, 32'hFFFF_FFFF, 1, 1, 100, -1);

        p = 0;
        while (items_sent < 850)
        begin
            n = $urandom_range(8, 1);
            r = $urandom_range(99);
            tx_steady = (p >= 20 && p < 32);
            if (p == 12)
                send_packet(PKT_SYN, sb.next_seq, 256, 1, 100, -1);
            else if (p == 40)
                send_packet(PKT_SYN, sb.next_seq, 257 + $urandom_range(3), 1, 100, -1);
            else if (!sb.in_session && r < 70)
                send_packet(PKT_SYN, 32'd0, n, r < 60, 85, -1);
            else if (r < 55)
                send_packet(PKT_SYN, sb.next_seq, n, 1, 85, -1);
            else if (r < 63)
                send_packet(PKT_SYN, sb.next_seq - 1, n, 1, 85, -1);
            else if (r < 71)
                send_packet(PKT_SYN, sb.next_seq, n, 0, 85, -1);
            else if (r < 78)
                send_packet(PKT_SYN, $urandom, n, 1, 85, -1);
            else if (r < 85)
                send_packet(PKT_FIN, $urandom, n, $urandom_range(1), 85, -1);
            else if (r < 93)
                send_packet(pkt_type_t'($urandom_range(3, 2)), $urandom, n, 1, 85, -1);
            else
                send_packet(pkt_type_t'($urandom_range(3)), $urandom, n, $urandom_range(1),
                            50, -1);
            p++;
        end
        tx_steady = 0;
        @(negedge clk);
        s_axis_tvalid = 1'b0;

        while (sb.replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
